>>> design/pmls_pkg.sv
package pmls_pkg;

   localparam int MAX_CUTS_DEF = 31;
   localparam int COORD_W      = 32;
   localparam int LEN_W        = 31;
   localparam int PEN_W        = 8;
   localparam int MAG_W        = 33;
   localparam int PROD_W       = 66;
   localparam int REM_W        = 35;
   localparam int UNIT_W       = 37;
   localparam int STEP_W       = 6;
   localparam int ROOT_STEPS   = 33;
   localparam int QUOT_STEPS   = 33;

   localparam logic REG_MAX_LENGTH   = 1'b0;
   localparam logic REG_WAYPOINT_PEN = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic [PEN_W-1:0]          pen_number;
      logic                      first_in_stroke;
      logic                      last_in_stroke;
   } pmls_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic [PEN_W-1:0]          out_pen;
      logic                      begins_piece;
      logic                      split_overflow;
      logic                      last_of_run;
   } pmls_rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      begins;
   } pmls_ent_type;

   typedef struct packed {
      logic         we;
      pmls_ent_type ent;
   } pmls_wr_type;

   typedef struct packed {
      logic             start;
      logic             ovf;
      logic [PEN_W-1:0] pen;
   } pmls_run_type;

endpackage

>>> design/polyline_max_length_split.sv
// Polyline splitter: cuts each input stroke into pieces no longer than max_length.
// Input channel req_*: one point per transaction, taken when req_valid is high and
// req_stall low. Result channel rsp_*: one or more points per input, the last one
// flagged last_of_run; held while rsp_stall is high. Config channel csr_*: index 0
// is max_length, index 1 is waypoint_pen; csr_ready is always high, write only
// while idle.
// A stroke start or bypassed point is stored directly, then drained. A regular
// point first measures the segment length (33-step square root); each cut then
// runs two divisions on the shared subtract/compare unit (one multiply each),
// stores the cut point twice and measures what is left of the segment; up to
// MAX_CUTS cuts. The end point is stored once, or twice if the budget is used up.
// Results are staged in an internal buffer and drained one at a time; req_stall
// stays high from acceptance until the last result has been taken.
// A stalled receiver simply holds the current result and the block waits.
// Reset: no stroke open, budget and previous point zero, max_length 0,
// waypoint_pen 255, no results pending.
module polyline_max_length_split
   import pmls_pkg::*;
#(
   parameter int MAX_CUTS = MAX_CUTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  pmls_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output pmls_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int DEPTH = 2 * MAX_CUTS + 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_CUTS + 1);

   logic          core_busy, buf_busy;
   pmls_wr_type   wr;
   logic [AW-1:0] wr_addr;
   pmls_run_type  run;
   logic [AW:0]   run_count;

   assign csr_ready = 1'b1;
   assign req_stall = core_busy || buf_busy;

   pmls_core #(
      .MAX_CUTS (MAX_CUTS),
      .DEPTH    (DEPTH),
      .AW       (AW),
      .CW       (CW)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_take  (req_valid && !req_stall),
      .req_data  (req_data),
      .busy      (core_busy),
      .wr        (wr),
      .wr_addr   (wr_addr),
      .run       (run),
      .run_count (run_count)
   );

   pmls_rbuf #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_rbuf (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .wr_addr   (wr_addr),
      .run       (run),
      .run_count (run_count),
      .busy      (buf_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> design/pmls_rbuf.sv
module pmls_rbuf
   import pmls_pkg::*;
#(
   parameter int DEPTH = 2 * MAX_CUTS_DEF + 2,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic         clock,
   input  logic         reset,
   input  pmls_wr_type  wr,
   input  logic [AW-1:0] wr_addr,
   input  pmls_run_type run,
   input  logic [AW:0]  run_count,
   output logic         busy,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output pmls_rsp_type rsp_data
);

   localparam logic [1:0] R_IDLE = 2'd0;
   localparam logic [1:0] R_READ = 2'd1;
   localparam logic [1:0] R_SHOW = 2'd2;

   pmls_ent_type     mem [DEPTH];
   pmls_ent_type     rdata_ff;
   logic [1:0]       state_ff, state_in;
   logic [AW-1:0]    rd_ff, rd_in;
   logic [AW:0]      count_ff;
   logic             ovf_ff;
   logic [PEN_W-1:0] pen_ff;
   logic             last_w;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr_addr] <= wr.ent;
      end
      if (state_ff == R_READ) begin
         rdata_ff <= mem[rd_ff];
      end
      if (run.start) begin
         count_ff <= run_count;
         ovf_ff   <= run.ovf;
         pen_ff   <= run.pen;
      end
   end

   assign last_w = (({1'b0, rd_ff} + 1'b1) == count_ff);

   always_comb begin
      state_in = state_ff;
      rd_in    = rd_ff;
      unique case (state_ff)
         R_IDLE: begin
            if (run.start) begin
               rd_in    = '0;
               state_in = R_READ;
            end
         end
         R_READ: state_in = R_SHOW;
         R_SHOW: begin
            if (!rsp_stall) begin
               if (last_w) begin
                  state_in = R_IDLE;
               end else begin
                  rd_in    = rd_ff + 1'b1;
                  state_in = R_READ;
               end
            end
         end
         default: state_in = R_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         rd_ff    <= '0;
      end else begin
         state_ff <= state_in;
         rd_ff    <= rd_in;
      end
   end

   assign busy      = (state_ff != R_IDLE);
   assign rsp_valid = (state_ff == R_SHOW);

   always_comb begin
      rsp_data.out_x          = rdata_ff.x;
      rsp_data.out_y          = rdata_ff.y;
      rsp_data.out_pen        = pen_ff;
      rsp_data.begins_piece   = rdata_ff.begins;
      rsp_data.split_overflow = ovf_ff;
      rsp_data.last_of_run    = last_w;
   end

endmodule

>>> design/pmls_core.sv
module pmls_core
   import pmls_pkg::*;
#(
   parameter int MAX_CUTS = MAX_CUTS_DEF,
   parameter int DEPTH    = 2 * MAX_CUTS + 2,
   parameter int AW       = $clog2(DEPTH),
   parameter int CW       = $clog2(MAX_CUTS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [31:0]   csr_wdata,
   input  logic          req_take,
   input  pmls_req_type  req_data,
   output logic          busy,
   output pmls_wr_type   wr,
   output logic [AW-1:0] wr_addr,
   output pmls_run_type  run,
   output logic [AW:0]   run_count
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MULX  = 4'd1;
   localparam logic [3:0] S_MULY  = 4'd2;
   localparam logic [3:0] S_SUM   = 4'd3;
   localparam logic [3:0] S_SQRT  = 4'd4;
   localparam logic [3:0] S_CHECK = 4'd5;
   localparam logic [3:0] S_MULC  = 4'd6;
   localparam logic [3:0] S_DIVI  = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_DIVE  = 4'd9;
   localparam logic [3:0] S_CUT1  = 4'd10;
   localparam logic [3:0] S_CUT2  = 4'd11;
   localparam logic [3:0] S_END1  = 4'd12;
   localparam logic [3:0] S_END2  = 4'd13;

   // control
   logic [3:0]        state_ff, state_in;
   logic [LEN_W-1:0]  max_len_ff, max_len_in;
   logic [PEN_W-1:0]  wp_ff, wp_in;
   logic [LEN_W-1:0]  budget_ff, budget_in;
   logic              bypass_ff, bypass_in;
   logic              open_ff, open_in;
   logic [CW-1:0]     cuts_ff, cuts_in;
   logic [AW:0]       n_ff, n_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              axis_ff, axis_in;
   logic              ovf_ff, ovf_in;
   logic signed [COORD_W-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;

   // payload
   logic signed [COORD_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_W-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [PEN_W-1:0]  pen_ff, pen_in;
   logic              last_ff, last_in;
   logic [PROD_W-1:0] prod_ff, prod_in, acc_ff, acc_in, rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [MAG_W-1:0]  root_ff, root_in, seg_ff, seg_in;

   // shared multiplier and subtract/compare unit
   logic [MAG_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] mul_p;
   logic [UNIT_W-1:0] unit_a, unit_b;
   logic [UNIT_W:0]   unit_d;
   logic              unit_ge;

   logic signed [MAG_W-1:0] dx_w, dy_w;
   logic [MAG_W-1:0]  magx, magy, mag_sel;
   logic              neg_sel;
   logic signed [COORD_W-1:0] base_sel;
   logic [COORD_W+1:0] cut_w;
   logic [PROD_W-1:0] div_sum;
   logic [LEN_W-1:0]  nb_w;
   logic              cut_more;

   assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign unit_d  = {1'b0, unit_a} - {1'b0, unit_b};
   assign unit_ge = !unit_d[UNIT_W];

   assign dx_w  = MAG_W'(cur_x_ff) - MAG_W'(ax_ff);
   assign dy_w  = MAG_W'(cur_y_ff) - MAG_W'(ay_ff);
   assign magx  = dx_w[MAG_W-1] ? MAG_W'(-dx_w) : MAG_W'(dx_w);
   assign magy  = dy_w[MAG_W-1] ? MAG_W'(-dy_w) : MAG_W'(dy_w);
   assign mag_sel  = axis_ff ? magy : magx;
   assign neg_sel  = axis_ff ? dy_w[MAG_W-1] : dx_w[MAG_W-1];
   assign base_sel = axis_ff ? ay_ff : ax_ff;
   assign cut_w    = neg_sel ? ({{2{base_sel[COORD_W-1]}}, base_sel} - {1'b0, root_ff})
                             : ({{2{base_sel[COORD_W-1]}}, base_sel} + {1'b0, root_ff});
   // rounding term: half the segment length
   assign div_sum  = prod_ff + PROD_W'(seg_ff[MAG_W-1:1]);
   assign nb_w     = ovf_ff ? '0 : (budget_ff - seg_ff[LEN_W-1:0]);
   assign cut_more = (root_ff > MAG_W'(budget_ff)) && (cuts_ff < CW'(MAX_CUTS));

   always_comb begin
      state_in   = state_ff;
      max_len_in = max_len_ff;
      wp_in      = wp_ff;
      budget_in  = budget_ff;
      bypass_in  = bypass_ff;
      open_in    = open_ff;
      cuts_in    = cuts_ff;
      n_in       = n_ff;
      cnt_in     = cnt_ff;
      axis_in    = axis_ff;
      ovf_in     = ovf_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      ax_in      = ax_ff;
      ay_in      = ay_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      pen_in     = pen_ff;
      last_in    = last_ff;
      prod_in    = prod_ff;
      acc_in     = acc_ff;
      rad_in     = rad_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      seg_in     = seg_ff;
      mul_a      = magx;
      mul_b      = magx;
      unit_a     = '0;
      unit_b     = '0;
      wr.we      = 1'b0;
      wr.ent.x   = cur_x_ff;
      wr.ent.y   = cur_y_ff;
      wr.ent.begins = 1'b0;
      wr_addr    = n_ff[AW-1:0];
      run.start  = 1'b0;
      run.ovf    = ovf_ff;
      run.pen    = pen_ff;
      run_count  = n_ff + 1'b1;

      if (csr_we) begin
         unique case (csr_index)
            REG_MAX_LENGTH:   max_len_in = csr_wdata[LEN_W-1:0];
            REG_WAYPOINT_PEN: wp_in      = csr_wdata[PEN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cur_x_in  = req_data.point_x;
               cur_y_in  = req_data.point_y;
               pen_in    = req_data.pen_number;
               last_in   = req_data.last_in_stroke;
               prev_x_in = req_data.point_x;
               prev_y_in = req_data.point_y;
               open_in   = !req_data.last_in_stroke;
               ax_in     = prev_x_ff;
               ay_in     = prev_y_ff;
               cuts_in   = '0;
               n_in      = '0;
               ovf_in    = 1'b0;
               wr.ent.x  = req_data.point_x;
               wr.ent.y  = req_data.point_y;
               wr_addr   = '0;
               run.ovf   = 1'b0;
               run.pen   = req_data.pen_number;
               run_count = (AW+1)'(1);
               if (req_data.first_in_stroke || !open_ff) begin
                  bypass_in = (max_len_ff == '0) || (req_data.pen_number == wp_ff)
                              || req_data.last_in_stroke;
                  budget_in = max_len_ff;
                  wr.we     = 1'b1;
                  wr.ent.begins = 1'b1;
                  run.start = 1'b1;
               end else if (bypass_ff || (max_len_ff == '0)) begin
                  wr.we     = 1'b1;
                  run.start = 1'b1;
               end else begin
                  state_in  = S_MULX;
               end
            end
         end
         S_MULX: begin
            prod_in  = mul_p;
            state_in = S_MULY;
         end
         S_MULY: begin
            mul_a    = magy;
            mul_b    = magy;
            prod_in  = mul_p;
            acc_in   = prod_ff;
            state_in = S_SUM;
         end
         S_SUM: begin
            rad_in   = acc_ff + prod_ff;
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            // restoring square root, two radicand bits per step
            unit_a  = {rem_ff, rad_ff[PROD_W-1:PROD_W-2]};
            unit_b  = {2'b00, root_ff, 2'b01};
            rem_in  = unit_ge ? unit_d[REM_W-1:0] : unit_a[REM_W-1:0];
            root_in = {root_ff[MAG_W-2:0], unit_ge};
            rad_in  = {rad_ff[PROD_W-3:0], 2'b00};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            seg_in  = root_ff;
            axis_in = 1'b0;
            if (cut_more) begin
               state_in = S_MULC;
            end else begin
               ovf_in   = (root_ff > MAG_W'(budget_ff));
               state_in = S_END1;
            end
         end
         S_MULC: begin
            mul_a    = MAG_W'(budget_ff);
            mul_b    = mag_sel;
            prod_in  = mul_p;
            state_in = S_DIVI;
         end
         S_DIVI: begin
            // quotient fits 33 bits, so the top bits already sit below the divisor
            rad_in   = div_sum;
            rem_in   = REM_W'(div_sum[PROD_W-1:QUOT_STEPS]);
            root_in  = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            unit_a  = UNIT_W'({rem_ff[MAG_W-1:0], rad_ff[QUOT_STEPS-1]});
            unit_b  = UNIT_W'(seg_ff);
            rem_in  = unit_ge ? unit_d[REM_W-1:0] : unit_a[REM_W-1:0];
            root_in = {root_ff[MAG_W-2:0], unit_ge};
            rad_in  = {rad_ff[PROD_W-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(QUOT_STEPS - 1)) begin
               state_in = S_DIVE;
            end
         end
         S_DIVE: begin
            if (!axis_ff) begin
               cx_in    = cut_w[COORD_W-1:0];
               axis_in  = 1'b1;
               state_in = S_MULC;
            end else begin
               cy_in    = cut_w[COORD_W-1:0];
               state_in = S_CUT1;
            end
         end
         S_CUT1: begin
            wr.we    = 1'b1;
            wr.ent.x = cx_ff;
            wr.ent.y = cy_ff;
            n_in     = n_ff + 1'b1;
            state_in = S_CUT2;
         end
         S_CUT2: begin
            wr.we    = 1'b1;
            wr.ent.x = cx_ff;
            wr.ent.y = cy_ff;
            wr.ent.begins = 1'b1;
            n_in     = n_ff + 1'b1;
            ax_in    = cx_ff;
            ay_in    = cy_ff;
            budget_in = max_len_ff;
            cuts_in  = cuts_ff + 1'b1;
            state_in = S_MULX;
         end
         S_END1: begin
            wr.we = 1'b1;
            if ((nb_w == '0) && !last_ff) begin
               budget_in = max_len_ff;
               n_in      = n_ff + 1'b1;
               state_in  = S_END2;
            end else begin
               budget_in = nb_w;
               run.start = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_END2: begin
            wr.we     = 1'b1;
            wr.ent.begins = 1'b1;
            run.start = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         max_len_ff <= '0;
         wp_ff      <= '1;
         budget_ff  <= '0;
         bypass_ff  <= 1'b0;
         open_ff    <= 1'b0;
         cuts_ff    <= '0;
         n_ff       <= '0;
         cnt_ff     <= '0;
         axis_ff    <= 1'b0;
         ovf_ff     <= 1'b0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         max_len_ff <= max_len_in;
         wp_ff      <= wp_in;
         budget_ff  <= budget_in;
         bypass_ff  <= bypass_in;
         open_ff    <= open_in;
         cuts_ff    <= cuts_in;
         n_ff       <= n_in;
         cnt_ff     <= cnt_in;
         axis_ff    <= axis_in;
         ovf_ff     <= ovf_in;
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      pen_ff   <= pen_in;
      last_ff  <= last_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      seg_ff   <= seg_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> tb/polyline_max_length_split_test.sv
`timescale 1ns / 1ps

module polyline_max_length_split_test;
   import pmls_pkg::*;

   localparam int CUT_LIMIT    = 31;
   localparam int IDLE_LIMIT   = 20000;
   localparam int RANDOM_ITEMS = 120;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   pmls_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   pmls_rsp_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic         csr_index;
   logic [31:0]  csr_wdata;

   polyline_max_length_split DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // predictor state
   logic [30:0]         cfg_max_length;
   logic [7:0]          cfg_waypoint_pen;
   logic signed [63:0]  last_x, last_y;
   logic [63:0]         budget;
   bit                  stroke_bypassed, in_stroke;

   pmls_rsp_type expected_points[$];
   int  error_count;
   int  points_checked;
   int  points_sent;
   int  idle_cycles;
   int  long_hold;
   bit  stall_random;

   typedef struct {
      pmls_req_type pt;
      bit           known;
      pmls_rsp_type first_rsp;
   } stim_row_type;

   function automatic logic [63:0] magnitude(logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [63:0] segment_length(logic signed [63:0] dx,
                                                  logic signed [63:0] dy);
      logic [65:0] sum;
      logic [65:0] rem;
      logic [65:0] root;
      sum = magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy);
      rem = '0;
      root = '0;
      for (int i = 32; i >= 0; i--) begin
         rem = (rem << 2) | ((sum >> (2 * i)) & 66'd3);
         root = root << 1;
         if (rem >= ((root << 1) | 66'd1)) begin
            rem = rem - ((root << 1) | 66'd1);
            root = root | 66'd1;
         end
      end
      return root[63:0];
   endfunction

   function automatic logic signed [63:0] cut_coord(logic signed [63:0] a,
                                                    logic signed [63:0] d,
                                                    logic [63:0] reach,
                                                    logic [63:0] seg);
      logic [127:0] q;
      q = ({64'd0, reach} * {64'd0, magnitude(d)} + {65'd0, seg[63:1]}) / {64'd0, seg};
      return d < 0 ? a - $signed(q[63:0]) : a + $signed(q[63:0]);
   endfunction

   function automatic pmls_rsp_type make_point(logic signed [63:0] x,
                                               logic signed [63:0] y,
                                               logic [7:0] pen, bit begins);
      pmls_rsp_type r;
      r.out_x = x[31:0];
      r.out_y = y[31:0];
      r.out_pen = pen;
      r.begins_piece = begins;
      r.split_overflow = 1'b0;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   task automatic predict_split(input pmls_req_type pt);
      pmls_rsp_type       run[$];
      logic signed [63:0] x, y, ax, ay, dx, dy, cx, cy;
      logic [63:0]        seg;
      int                 cuts;
      bit                 ovf;
      x = 64'(pt.point_x);
      y = 64'(pt.point_y);
      ovf = 1'b0;
      if (pt.first_in_stroke || !in_stroke) begin
         stroke_bypassed = (cfg_max_length == 0) || (pt.pen_number == cfg_waypoint_pen) ||
                           pt.last_in_stroke;
         budget = 64'(cfg_max_length);
         run = {run, make_point(x, y, pt.pen_number, 1'b1)};
      end else if (stroke_bypassed || cfg_max_length == 0) begin
         run = {run, make_point(x, y, pt.pen_number, 1'b0)};
      end else begin
         ax = last_x;
         ay = last_y;
         dx = x - ax;
         dy = y - ay;
         seg = segment_length(dx, dy);
         cuts = 0;
         while (seg > budget && cuts < CUT_LIMIT) begin
            cx = cut_coord(ax, dx, budget, seg);
            cy = cut_coord(ay, dy, budget, seg);
            run = {run, make_point(cx, cy, pt.pen_number, 1'b0)};
            run = {run, make_point(cx, cy, pt.pen_number, 1'b1)};
            ax = cx;
            ay = cy;
            dx = x - ax;
            dy = y - ay;
            seg = segment_length(dx, dy);
            budget = 64'(cfg_max_length);
            cuts++;
         end
         ovf = seg > budget;
         run = {run, make_point(x, y, pt.pen_number, 1'b0)};
         budget = ovf ? 64'd0 : budget - seg;
         if (budget == 0 && !pt.last_in_stroke) begin
            run = {run, make_point(x, y, pt.pen_number, 1'b1)};
            budget = 64'(cfg_max_length);
         end
      end
      last_x = x;
      last_y = y;
      in_stroke = !pt.last_in_stroke;
      foreach (run[k]) run[k].split_overflow = ovf;
      run[run.size() - 1].last_of_run = 1'b1;
      expected_points = {expected_points, run};
   endtask

   function automatic pmls_req_type make_req(int x, int y, int pen, bit f, bit l);
      pmls_req_type p;
      p.point_x = x;
      p.point_y = y;
      p.pen_number = pen[7:0];
      p.first_in_stroke = f;
      p.last_in_stroke = l;
      return p;
   endfunction

   task automatic send_point(input pmls_req_type pt);
      req_valid <= 1'b1;
      req_data <= pt;
      do @(posedge clock); while (req_stall);
      predict_split(pt);
      points_sent++;
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == REG_MAX_LENGTH) cfg_max_length = value[30:0];
      else cfg_waypoint_pen = value[7:0];
   endtask

   // checker and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("polyline_max_length_split_test: done, errors");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               $error("unexpected result x=%h y=%h", rsp_data.out_x, rsp_data.out_y);
               error_count++;
            end else begin
               pmls_rsp_type e;
               e = expected_points.pop_front();
               points_checked++;
               if (e.out_x !== rsp_data.out_x) begin
                  $error("out_x exp %h got %h", e.out_x, rsp_data.out_x);
                  error_count++;
               end
               if (e.out_y !== rsp_data.out_y) begin
                  $error("out_y exp %h got %h", e.out_y, rsp_data.out_y);
                  error_count++;
               end
               if (e.out_pen !== rsp_data.out_pen) begin
                  $error("out_pen exp %h got %h", e.out_pen, rsp_data.out_pen);
                  error_count++;
               end
               if (e.begins_piece !== rsp_data.begins_piece) begin
                  $error("begins_piece exp %b got %b", e.begins_piece, rsp_data.begins_piece);
                  error_count++;
               end
               if (e.split_overflow !== rsp_data.split_overflow) begin
                  $error("split_overflow exp %b got %b", e.split_overflow,
                         rsp_data.split_overflow);
                  error_count++;
               end
               if (e.last_of_run !== rsp_data.last_of_run) begin
                  $error("last_of_run exp %b got %b", e.last_of_run, rsp_data.last_of_run);
                  error_count++;
               end
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold > 0) begin
         rsp_stall <= 1'b1;
         long_hold <= long_hold - 1;
      end else if (stall_random) begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic int rand_coord(int span);
      return $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   stim_row_type directed[$];

   initial begin
      stim_row_type row;
      pmls_req_type pt;
      int burst, px, py, npts;
      error_count = 0;
      points_checked = 0;
      points_sent = 0;
      idle_cycles = 0;
      long_hold = 0;
      stall_random = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = REG_MAX_LENGTH;
      csr_wdata = '0;
      cfg_max_length = '0;
      cfg_waypoint_pen = 8'hFF;
      last_x = 0;
      last_y = 0;
      budget = 0;
      stroke_bypassed = 0;
      in_stroke = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset: splitting off, everything passes through
      row.known = 1;
      row.pt = make_req(32'h7FFFFFFF, 32'h80000000, 0, 0, 0);
      row.first_rsp = '{out_x: 32'h7FFFFFFF, out_y: 32'h80000000, out_pen: 0,
                        begins_piece: 1, split_overflow: 0, last_of_run: 1};
      directed = {directed, row};
      row.pt = make_req(32'h80000000, 32'h7FFFFFFF, 255, 0, 1);
      row.first_rsp = '{out_x: 32'h80000000, out_y: 32'h7FFFFFFF, out_pen: 255,
                        begins_piece: 0, split_overflow: 0, last_of_run: 1};
      directed = {directed, row};
      row.pt = make_req(5, 6, 8'hAA, 1, 1);
      row.first_rsp = '{out_x: 5, out_y: 6, out_pen: 8'hAA,
                        begins_piece: 1, split_overflow: 0, last_of_run: 1};
      directed = {directed, row};
      foreach (directed[i]) begin
         send_point(directed[i].pt);
         if (directed[i].known && expected_points[0] !== directed[i].first_rsp) begin
            $error("directed row %0d: table and predictor disagree", i);
            error_count++;
         end
      end
      wait_drained();

      write_reg(REG_MAX_LENGTH, 32'd1000);
      write_reg(REG_WAYPOINT_PEN, 32'd3);
      directed.delete();
      row.known = 0;
      // exact budget hits, cuts, diagonal, waypoint pen, mixed pens, one-point stroke
      row.pt = make_req(0, 0, 1, 1, 0);          directed = {directed, row};
      row.pt = make_req(1000, 0, 1, 0, 0);       directed = {directed, row};
      row.pt = make_req(1000, 2500, 1, 0, 0);    directed = {directed, row};
      row.pt = make_req(-700, -300, 2, 0, 0);    directed = {directed, row};
      row.pt = make_req(-701, -301, 1, 0, 1);    directed = {directed, row};
      row.pt = make_req(10, 10, 3, 1, 0);        directed = {directed, row};
      row.pt = make_req(90000, 10, 1, 0, 1);     directed = {directed, row};
      row.pt = make_req(7, 7, 1, 1, 1);          directed = {directed, row};
      row.pt = make_req(0, 0, 4, 1, 0);          directed = {directed, row};
      // far more than the cut bound: overflow
      row.pt = make_req(32'h7FFFFFFF, 32'h7FFFFFFF, 4, 0, 0); directed = {directed, row};
      row.pt = make_req(32'h80000000, 32'h80000000, 4, 0, 1); directed = {directed, row};
      foreach (directed[i]) send_point(directed[i].pt);
      wait_drained();

      // largest max_length, waypoint pen 0, then a mid-stroke register change
      write_reg(REG_MAX_LENGTH, 32'h7FFFFFFF);
      write_reg(REG_WAYPOINT_PEN, 32'd0);
      send_point(make_req(32'h80000000, 32'h80000000, 0, 1, 0));
      send_point(make_req(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 1));
      send_point(make_req(32'h80000000, 0, 9, 1, 0));
      send_point(make_req(32'h7FFFFFFF, 0, 9, 0, 0));
      wait_drained();
      write_reg(REG_MAX_LENGTH, 32'd1);
      send_point(make_req(32'h7FFFFFF0, 0, 9, 0, 0));
      send_point(make_req(32'h7FFFFFF0, 3, 9, 0, 1));
      wait_drained();

      // long receiver hold-off while the sender keeps offering
      write_reg(REG_MAX_LENGTH, 32'd300);
      long_hold <= 400;
      fork
         begin
            send_point(make_req(0, 0, 5, 1, 0));
            send_point(make_req(1000, 0, 5, 0, 0));
            send_point(make_req(1000, 1000, 5, 0, 0));
            send_point(make_req(0, 0, 5, 0, 1));
         end
      join
      wait_drained();
      stall_random = 1'b1;

      // random strokes, config changed between phases
      while (points_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            wait_drained();
            case ($urandom_range(0, 3))
               0: write_reg(REG_MAX_LENGTH, 32'd0);
               1: write_reg(REG_MAX_LENGTH, $urandom_range(1, 64));
               2: write_reg(REG_MAX_LENGTH, $urandom_range(64, 5000));
               default: write_reg(REG_MAX_LENGTH, {1'b0, $urandom()} >> 1);
            endcase
            write_reg(REG_WAYPOINT_PEN, $urandom_range(0, 255));
            stall_random = $urandom_range(0, 2) != 0;
         end
         npts = $urandom_range(1, 6);
         px = rand_coord(20000);
         py = rand_coord(20000);
         burst = $urandom_range(1, 5);
         for (int k = 0; k < npts; k++) begin
            if (k > 0) begin
               if ($urandom_range(0, 9) == 0) begin
                  px = $urandom();
                  py = $urandom();
               end else begin
                  px = px + rand_coord(3000);
                  py = py + rand_coord(3000);
               end
            end
            pt = make_req(px, py, $urandom_range(0, 7), k == 0, k == npts - 1);
            if ($urandom_range(0, 15) == 0) begin
               // broken stroke: random flags and pen
               pt.first_in_stroke = $urandom_range(0, 1);
               pt.last_in_stroke = $urandom_range(0, 1);
               pt.pen_number = $urandom_range(0, 255);
            end
            send_point(pt);
            if (--burst == 0) begin
               idle_sender($urandom_range(1, 12));
               burst = $urandom_range(1, 5);
            end
         end
      end
      wait_drained();

      $display("covered %0d input points, %0d results checked", points_sent, points_checked);
      $display("directed extremes, cut overflow, long receiver stall, random strokes");
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("polyline_max_length_split_test: done, clean");
      end else begin
         $display("polyline_max_length_split_test: done, errors");
      end
      $finish;
   end

endmodule
